[rtl/css_position_resolver_macros.svh]
// Assertion macros for the position resolver checker.
`ifndef CSS_POSITION_RESOLVER_MACROS_SVH
`define CSS_POSITION_RESOLVER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CSS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/css_pkg.sv]
// Types, constants and helpers shared by the position resolver.
package css_pkg;

  localparam int COORD_BITS   = 24;
  localparam int WIDE_BITS    = COORD_BITS + 4;
  localparam int OP_BITS      = 3;
  localparam int PRES_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-2:0] usize_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  typedef enum logic [OP_BITS-1:0] {
    MODE_STATIC   = 3'd0,
    MODE_RELATIVE = 3'd1,
    MODE_ABSOLUTE = 3'd2,
    MODE_FIXED    = 3'd3,
    MODE_STICKY   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CONTAINER_X      = 2'd0,
    CFG_CONTAINER_Y      = 2'd1,
    CFG_CONTAINER_WIDTH  = 2'd2,
    CFG_CONTAINER_HEIGHT = 2'd3
  } cfg_idx_e;

  localparam int PRES_TOP    = 0;
  localparam int PRES_BOTTOM = 1;
  localparam int PRES_LEFT   = 2;
  localparam int PRES_RIGHT  = 3;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    coord_t               box_x;
    coord_t               box_y;
    coord_t               box_width;
    coord_t               box_height;
    coord_t               offset_top;
    coord_t               offset_bottom;
    coord_t               offset_left;
    coord_t               offset_right;
    logic [PRES_BITS-1:0] offset_present;
    usize_t               natural_width;
    usize_t               natural_height;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_width;
    coord_t out_height;
  } out_item_t;

  typedef struct packed {
    coord_t container_x;
    coord_t container_y;
    usize_t container_width;
    usize_t container_height;
  } frame_t;

  typedef struct packed {
    logic   has_lead;
    logic   has_trail;
    coord_t lead;
    coord_t trail;
    coord_t pos;
    coord_t size;
    usize_t natural;
    coord_t origin;
    usize_t extent;
  } axis_in_t;

  typedef struct packed {
    coord_t pos;
    coord_t size;
  } axis_out_t;

  localparam wide_t WIDE_MAX = {{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam wide_t WIDE_MIN = ~WIDE_MAX;

  function automatic wide_t sx(coord_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t zx(usize_t v);
    return wide_t'({1'b0, v});
  endfunction

  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[COORD_BITS-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/css_axis.sv]
// One-axis position and size resolution for every positioning mode.
module css_axis
  import css_pkg::*;
(
  input  logic [OP_BITS-1:0] op_i,
  input  axis_in_t           axis_i,
  output axis_out_t          axis_o
);

  wide_t lead_w, trail_w, pos_w, size_w, nat_w, org_w, ext_w;
  wide_t size_fill, far_edge, pos_r, size_r, tmp;

  always_comb begin
    lead_w    = sx(axis_i.lead);
    trail_w   = sx(axis_i.trail);
    pos_w     = sx(axis_i.pos);
    size_w    = sx(axis_i.size);
    nat_w     = zx(axis_i.natural);
    org_w     = sx(axis_i.origin);
    ext_w     = zx(axis_i.extent);
    size_fill = (size_w <= 0) ? nat_w : size_w;
    far_edge  = org_w + ext_w - size_w;
    pos_r     = pos_w;
    size_r    = size_w;
    tmp       = pos_w;
    unique case (op_i)
      MODE_RELATIVE: begin
        priority if (axis_i.has_lead) begin
          pos_r = pos_w + lead_w;
        end else if (axis_i.has_trail) begin
          pos_r = pos_w - trail_w;
        end else begin
        end
      end
      MODE_ABSOLUTE, MODE_FIXED: begin
        priority if (axis_i.has_lead && axis_i.has_trail) begin
          pos_r  = org_w + lead_w;
          size_r = ext_w - lead_w - trail_w;
        end else if (axis_i.has_lead) begin
          pos_r  = org_w + lead_w;
          size_r = size_fill;
        end else if (axis_i.has_trail) begin
          pos_r  = org_w + ext_w - size_fill - trail_w;
          size_r = size_fill;
        end else begin
          pos_r  = org_w;
          size_r = size_fill;
        end
        if (size_r < 0) begin
          size_r = '0;
        end
      end
      MODE_STICKY: begin
        if (axis_i.has_lead) begin
          tmp   = (pos_w > org_w + lead_w) ? pos_w : org_w + lead_w;
          pos_r = (tmp < far_edge) ? tmp : far_edge;
        end
        if (axis_i.has_trail) begin
          tmp   = (pos_w < far_edge - trail_w) ? pos_w : far_edge - trail_w;
          pos_r = (tmp > org_w) ? tmp : org_w;
        end
      end
      default: begin
      end
    endcase
    axis_o.pos  = sat_coord(pos_r);
    axis_o.size = sat_coord(size_r);
  end

endmodule

[rtl/css_position_resolver.sv]
// Top level of the positioned-box resolver: config, input and result registers.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One box per cycle while the result is not stalled; a result is offered once its
// transaction has gone through the input register, the axis logic and the result
// register. Reset clears the container registers and both valid flags.
// A stalled result holds; the input register keeps filling until both stages hold.
module css_position_resolver
  import css_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i
);

  frame_t    frame_q;
  in_item_t  item_q;
  logic      item_valid_q, out_valid_q;
  out_item_t out_q, out_d;
  axis_in_t  x_in, y_in;
  axis_out_t x_out, y_out;
  logic      adv_out, adv_in;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv_in     = !item_valid_q || adv_out;
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CONTAINER_X:      frame_q.container_x      <= coord_t'(cfg_data_i);
        CFG_CONTAINER_Y:      frame_q.container_y      <= coord_t'(cfg_data_i);
        CFG_CONTAINER_WIDTH:  frame_q.container_width  <= cfg_data_i[COORD_BITS-2:0];
        CFG_CONTAINER_HEIGHT: frame_q.container_height <= cfg_data_i[COORD_BITS-2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv_in) begin
        item_valid_q <= in_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (adv_out && item_valid_q) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    x_in.has_lead  = item_q.offset_present[PRES_LEFT];
    x_in.has_trail = item_q.offset_present[PRES_RIGHT];
    x_in.lead      = item_q.offset_left;
    x_in.trail     = item_q.offset_right;
    x_in.pos       = item_q.box_x;
    x_in.size      = item_q.box_width;
    x_in.natural   = item_q.natural_width;
    x_in.origin    = frame_q.container_x;
    x_in.extent    = frame_q.container_width;
    y_in.has_lead  = item_q.offset_present[PRES_TOP];
    y_in.has_trail = item_q.offset_present[PRES_BOTTOM];
    y_in.lead      = item_q.offset_top;
    y_in.trail     = item_q.offset_bottom;
    y_in.pos       = item_q.box_y;
    y_in.size      = item_q.box_height;
    y_in.natural   = item_q.natural_height;
    y_in.origin    = frame_q.container_y;
    y_in.extent    = frame_q.container_height;
  end

  css_axis u_axis_x (
    .op_i   (item_q.op),
    .axis_i (x_in),
    .axis_o (x_out)
  );

  css_axis u_axis_y (
    .op_i   (item_q.op),
    .axis_i (y_in),
    .axis_o (y_out)
  );

  always_comb begin
    out_d.out_x      = x_out.pos;
    out_d.out_y      = y_out.pos;
    out_d.out_width  = x_out.size;
    out_d.out_height = y_out.size;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/css_checker.sv]
// Port-level checks for the position resolver, bound to the top level.
`include "css_position_resolver_macros.svh"

module css_checker
  import css_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `CSS_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o,
                  "result valid during reset")

  `CSS_ASSERT(a_out_hold,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
              "stalled result dropped or changed")

  `CSS_ASSERT(a_latency, in_valid_i && !in_stall_o |-> ##2 out_valid_o,
              "accepted transaction produced no result")

  `CSS_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i,
              "input stalled without output backpressure")

endmodule

bind css_position_resolver css_checker u_css_checker (.*);
